>>> design/bct_pkg.sv
package bct_pkg;

  // Field widths fixed by the item and register formats
  localparam int CMD_W        = 2;
  localparam int PIX_W        = 8;
  localparam int COORD_W      = 8;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;

  // Default bitmap bounds
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Register values after reset
  localparam int RESET_SIZE   = 256;
  localparam int RESET_THRESH = 0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRACE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PIX_W-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0]  point_x;
    logic [COORD_W-1:0]  point_y;
    logic [STATUS_W-1:0] status;
    logic                last_point;
  } out_t;

endpackage

>>> design/binary_contour_tracer.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  in_data_i  (command, pixel_value)
// out       output     out_valid_o / out_stall_i out_data_o (point_x, point_y, status, last_point)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Begin frame and load pixel do not hold the input; the first foreground pixel of a frame holds
// the input while the serial divider splits its raster index into column and row. A walking
// trace step checks its neighbors in turn, reading the bitmap for each in-bounds one, pipelined,
// until a foreground neighbor is found; a status-only one goes straight from entry to its result.
// Reset clears control state only; the bitmap holds garbage until loaded.
// A stalled output holds its register; loads go on, a later trace result waits in the core.
module binary_contour_tracer #(
  parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bct_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bct_pkg::out_t                       out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bct_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bct_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import bct_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [PIX_W-1:0]      thresh_q;
  logic [WW-1:0]         eff_w;
  logic [HW-1:0]         eff_h;

  logic                  in_xfer;
  logic                  core_busy;
  logic                  core_res_valid;
  logic                  core_res_ready;
  out_t                  core_res;

  logic                  out_valid_q, out_valid_d;
  out_t                  out_data_q;
  logic                  out_load;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(RESET_SIZE);
      height_q <= CFG_DATA_W'(RESET_SIZE);
      thresh_q <= PIX_W'(RESET_THRESH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_THRESH: thresh_q <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to 1..MAX
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  // Input transfer only while the core sits idle
  assign in_stall_o = core_busy;
  assign in_xfer    = in_valid_i && !in_stall_o;

  bct_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_xfer),
    .item_i       (in_data_i),
    .eff_w_i      (eff_w),
    .eff_h_i      (eff_h),
    .thresh_i     (thresh_q),
    .busy_o       (core_busy),
    .res_valid_o  (core_res_valid),
    .res_ready_i  (core_res_ready),
    .res_o        (core_res)
  );

  // Output register: refill when empty or when its result leaves this cycle
  assign core_res_ready = !out_valid_q || !out_stall_i;
  assign out_load       = core_res_valid && core_res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= core_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A trace step always occupies the core and holds the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.command == CMD_TRACE) |=> in_stall_o)
    else $error("trace step did not hold the input");

  // Begin frame finishes at once and gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.command == CMD_BEGIN) |=> !in_stall_o && !core_res_valid)
    else $error("begin frame left the core busy");

  // A pending core result keeps the input stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_res_valid |-> in_stall_o)
    else $error("input taken while a result is pending");

  // Error results carry zero coordinates and no closing flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |->
      !out_data_o.last_point && (out_data_o.point_x == '0) && (out_data_o.point_y == '0))
    else $error("error result carries a point");

endmodule

>>> design/bct_div.sv
module bct_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // One quotient bit per cycle, restoring form
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quot_q[NUM_W-1]};
    qbit   = (trial >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NUM_W);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = qbit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quot_d = {quot_q[NUM_W-2:0], qbit};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> design/bct_core.sv
module bct_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  bct_pkg::in_t   item_i,
  input  logic [WW-1:0]  eff_w_i,
  input  logic [HW-1:0]  eff_h_i,
  input  logic [7:0]     thresh_i,
  output logic           busy_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output bct_pkg::out_t  res_o
);

  import bct_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  localparam logic [1:0] PH_LOAD  = 2'd0;
  localparam logic [1:0] PH_TRACE = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [2:0] DIR_N  = 3'd0;
  localparam logic [2:0] DIR_NE = 3'd1;
  localparam logic [2:0] DIR_E  = 3'd2;
  localparam logic [2:0] DIR_SE = 3'd3;
  localparam logic [2:0] DIR_S  = 3'd4;
  localparam logic [2:0] DIR_SW = 3'd5;
  localparam logic [2:0] DIR_W  = 3'd6;
  localparam logic [2:0] DIR_NW = 3'd7;
  localparam logic [2:0] DIR_BACK = 3'd6;

  logic [1:0]    state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic [IW-1:0] load_idx_q, load_idx_d;
  logic          start_seen_q, start_seen_d;
  logic [XW-1:0] start_x_q, start_x_d;
  logic [YW-1:0] start_y_q, start_y_d;
  logic [XW-1:0] cur_x_q, cur_x_d;
  logic [YW-1:0] cur_y_q, cur_y_d;
  logic [2:0]    dir_q, dir_d;
  logic [3:0]    k_q, k_d;
  logic          rd_pend_q, rd_pend_d;
  logic          rd_inb_q, rd_inb_d;
  logic [2:0]    rd_dir_q, rd_dir_d;
  logic [XW-1:0] rd_nx_q, rd_nx_d;
  logic [YW-1:0] rd_ny_q, rd_ny_d;
  out_t          res_q, res_d;
  logic          rd_bit_q;

  logic          bitmap_mem [DEPTH];

  logic [IW-1:0] area;
  logic          load_ok;
  logic          fg;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [2:0]    iss_dir;
  logic          inc_x, dec_x, inc_y, dec_y;
  logic [XW:0]   nx_ext;
  logic [YW:0]   ny_ext;
  logic          inb;
  logic          hit;
  logic          is_last;
  logic          div_start;
  logic          div_done;
  logic [AW-1:0] div_quot;
  logic [WW-1:0] div_rem;

  assign area    = IW'(IW'(eff_w_i) * IW'(eff_h_i));
  assign load_ok = (load_idx_q < area);
  assign fg      = (item_i.pixel_value > thresh_i);

  // Neighbor position for the direction issued this cycle
  assign iss_dir = dir_q + k_q[2:0];

  always_comb begin
    inc_x = 1'b0;
    dec_x = 1'b0;
    inc_y = 1'b0;
    dec_y = 1'b0;
    case (iss_dir)
      DIR_N:  dec_y = 1'b1;
      DIR_NE: begin inc_x = 1'b1; dec_y = 1'b1; end
      DIR_E:  inc_x = 1'b1;
      DIR_SE: begin inc_x = 1'b1; inc_y = 1'b1; end
      DIR_S:  inc_y = 1'b1;
      DIR_SW: begin dec_x = 1'b1; inc_y = 1'b1; end
      DIR_W:  dec_x = 1'b1;
      DIR_NW: begin dec_x = 1'b1; dec_y = 1'b1; end
      default: ;
    endcase
  end

  // A step off the left or top wraps to all ones and fails the bound check
  always_comb begin
    nx_ext = {1'b0, cur_x_q};
    ny_ext = {1'b0, cur_y_q};
    if (inc_x) nx_ext = nx_ext + (XW+1)'(1);
    if (dec_x) nx_ext = nx_ext - (XW+1)'(1);
    if (inc_y) ny_ext = ny_ext + (YW+1)'(1);
    if (dec_y) ny_ext = ny_ext - (YW+1)'(1);
  end

  assign inb     = (nx_ext < eff_w_i) && (ny_ext < eff_h_i);
  assign rd_addr = AW'(AW'(ny_ext[YW-1:0]) * AW'(eff_w_i)) + AW'(nx_ext[XW-1:0]);
  assign hit     = (state_q == S_SCAN) && rd_pend_q && rd_inb_q && rd_bit_q;
  assign is_last = (rd_nx_q == start_x_q) && (rd_ny_q == start_y_q);
  assign rd_en   = (state_q == S_SCAN) && !hit && !k_q[3] && inb;
  assign wr_en   = (state_q == S_IDLE) && item_valid_i &&
                   (item_i.command == CMD_LOAD) && load_ok;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    load_idx_d   = load_idx_q;
    start_seen_d = start_seen_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    dir_d        = dir_q;
    k_d          = k_q;
    rd_pend_d    = rd_pend_q;
    rd_inb_d     = rd_inb_q;
    rd_dir_d     = rd_dir_q;
    rd_nx_d      = rd_nx_q;
    rd_ny_d      = rd_ny_q;
    res_d        = res_q;
    div_start    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          case (item_i.command)
            CMD_BEGIN: begin
              load_idx_d   = '0;
              start_seen_d = 1'b0;
              start_x_d    = '0;
              start_y_d    = '0;
              dir_d        = DIR_N;
              phase_d      = PH_LOAD;
            end
            CMD_LOAD: begin
              if (load_ok) begin
                load_idx_d = load_idx_q + IW'(1);
                // First foreground pixel: split its index into column and row
                if (fg && !start_seen_q) begin
                  start_seen_d = 1'b1;
                  div_start    = 1'b1;
                  state_d      = S_DIV;
                end
              end
            end
            CMD_TRACE: begin
              res_d = '0;
              if (!start_seen_q) begin
                res_d.status = STATUS_NO_FG;
                state_d      = S_RESULT;
              end else if (phase_q == PH_DONE) begin
                res_d.status = STATUS_DONE;
                state_d      = S_RESULT;
              end else begin
                if (phase_q == PH_LOAD) begin
                  cur_x_d = start_x_q;
                  cur_y_d = start_y_q;
                  dir_d   = DIR_N;
                  phase_d = PH_TRACE;
                end
                k_d       = '0;
                rd_pend_d = 1'b0;
                state_d   = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          start_x_d = XW'(div_rem);
          start_y_d = YW'(div_quot);
          state_d   = S_IDLE;
        end
      end
      S_SCAN: begin
        res_d.point_x = COORD_W'(cur_x_q);
        res_d.point_y = COORD_W'(cur_y_q);
        res_d.status  = STATUS_OK;
        if (hit) begin
          dir_d            = rd_dir_q + DIR_BACK;
          res_d.last_point = is_last;
          if (is_last) begin
            phase_d = PH_DONE;
          end else begin
            cur_x_d = rd_nx_q;
            cur_y_d = rd_ny_q;
          end
          rd_pend_d = 1'b0;
          state_d   = S_RESULT;
        end else if (k_q[3]) begin
          // All eight neighbors clear: isolated point closes the contour
          res_d.last_point = 1'b1;
          phase_d          = PH_DONE;
          rd_pend_d        = 1'b0;
          state_d          = S_RESULT;
        end else begin
          rd_pend_d = 1'b1;
          rd_inb_d  = inb;
          rd_dir_d  = iss_dir;
          rd_nx_d   = nx_ext[XW-1:0];
          rd_ny_d   = ny_ext[YW-1:0];
          k_d       = k_q + 4'd1;
        end
      end
      S_RESULT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_LOAD;
      load_idx_q   <= '0;
      start_seen_q <= 1'b0;
      dir_q        <= DIR_N;
      k_q          <= '0;
      rd_pend_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      load_idx_q   <= load_idx_d;
      start_seen_q <= start_seen_d;
      dir_q        <= dir_d;
      k_q          <= k_d;
      rd_pend_q    <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_x_q <= start_x_d;
    start_y_q <= start_y_d;
    cur_x_q   <= cur_x_d;
    cur_y_q   <= cur_y_d;
    rd_inb_q  <= rd_inb_d;
    rd_dir_q  <= rd_dir_d;
    rd_nx_q   <= rd_nx_d;
    rd_ny_q   <= rd_ny_d;
    res_q     <= res_d;
  end

  // Bitmap: writes only while loading, reads only while scanning
  always_ff @(posedge clk_i) begin
    if (wr_en) bitmap_mem[load_idx_q[AW-1:0]] <= fg;
    if (rd_en) rd_bit_q <= bitmap_mem[rd_addr];
  end

  bct_div #(
    .NUM_W (AW),
    .DEN_W (WW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (load_idx_q[AW-1:0]),
    .den_i   (eff_w_i),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

endmodule
